// ===== hdl/bsw_pkg.sv =====
// shared types, constants and config decode for the blended saturation waveshaper
`timescale 1ns / 1ps
`default_nettype none

package bsw_pkg;

   // sample format
   localparam int SAMPLE_WIDTH = 24;
   localparam int INT_FRAC     = 24;
   localparam int FRAC_BITS    = SAMPLE_WIDTH - 4;
   localparam int UP_SHIFT     = (FRAC_BITS < INT_FRAC) ? INT_FRAC - FRAC_BITS : 0;
   localparam int DN_SHIFT     = (FRAC_BITS > INT_FRAC) ? FRAC_BITS - INT_FRAC : 0;

   // amount register and derived settings
   localparam int AMT_WIDTH    = 16;
   localparam int AMT_BITS     = 14;
   localparam int AMT_ONE      = 1 << AMT_BITS;
   localparam int BYPASS_MAX   = 16;
   localparam int DRIVE_BASE   = 1802240;
   localparam int DRIVE_STEP   = 15;
   // drive and scale denominator share a factor of five, kept divided out
   localparam int DRIVE_DIV    = 5;
   localparam int DRIVE_Q_BASE = DRIVE_BASE / DRIVE_DIV;
   localparam int DRIVE_Q_STEP = DRIVE_STEP / DRIVE_DIV;
   localparam int DRIVE_WIDTH  = 20;
   localparam int THR_WIDTH    = 25;
   localparam int THR_BASE_DIV = 147456;
   localparam int THR_Q_WIDTH  = 18;
   localparam int RECIP5       = 52429;
   localparam int RECIP5_SHIFT = 18;
   localparam int THR_FRAC_SH  = 9;
   localparam int WET_WIDTH    = AMT_BITS + 1;

   // internal magnitude path, Q.24
   localparam int ONE_Q        = 1 << INT_FRAC;
   localparam int ONE_HALF     = 1 << (INT_FRAC - 1);
   localparam int M_WIDTH      = 28;
   localparam int Q_WIDTH      = 28;
   localparam int SCALE_DEN    = 1638400;
   // scale denominator over five is 5 * 2^16: shift, then divide by five
   localparam int M_SHIFT      = 16 + DN_SHIFT;
   localparam int M_HALF       = DRIVE_DIV << (M_SHIFT - 1);
   localparam int T_WIDTH      = 32;
   localparam logic [31:0] MSC_RECIP = 32'hCCCC_CCCD;
   localparam int MSC_RECIP_SHIFT = 34;
   localparam int MNUM_WIDTH   = SAMPLE_WIDTH + DRIVE_WIDTH + UP_SHIFT + 1;
   localparam int X2_WIDTH     = 32;
   localparam int PNUM_WIDTH   = 62;
   localparam int PDEN_WIDTH   = 35;
   localparam int PADE_C       = 27;
   localparam int SNUM_WIDTH   = 50;
   localparam int SDEN_WIDTH   = 34;
   localparam int SMALL_WIDTH  = INT_FRAC + 1;
   localparam int SUM_WIDTH    = 32;
   localparam int MIX_HALF     = 5;
   localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
   localparam int RECIP10_SHIFT = 35;

   // one lane: drive product, scaling, one divider pass and six further single stages
   localparam int LANE_LATENCY = Q_WIDTH + 8;
   localparam int TOP_LATENCY  = LANE_LATENCY + 2;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] left_sample;
      logic signed [SAMPLE_WIDTH-1:0] right_sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] left_out;
      logic signed [SAMPLE_WIDTH-1:0] right_out;
   } rsp_type;

   typedef struct packed {
      logic [DRIVE_WIDTH-1:0] drive;
      logic [THR_WIDTH-1:0]   thr;
      logic [WET_WIDTH-1:0]   wet;
      logic                   bypass;
   } cfg_type;

   // settings that depend on amount only
   function automatic cfg_type cfg_decode(input logic [AMT_WIDTH-1:0] amount);
      logic [THR_Q_WIDTH-1:0]   v;
      logic [2*THR_Q_WIDTH-1:0] prod;
      logic [THR_Q_WIDTH-1:0]   q;
      logic [2:0]               r;
      logic [THR_FRAC_SH:0]     frac;
      cfg_type                  c;
      // thr = round(512 * (147456 + amount) / 5), split as 512*q + round(512*r/5)
      v    = THR_Q_WIDTH'(THR_BASE_DIV) + THR_Q_WIDTH'(amount);
      prod = (2*THR_Q_WIDTH)'(v) * (2*THR_Q_WIDTH)'(RECIP5);
      q    = THR_Q_WIDTH'(prod >> RECIP5_SHIFT);
      r    = 3'(v - THR_Q_WIDTH'(q * THR_Q_WIDTH'(5)));
      case (r)
         3'd1:    frac = 10'd102;
         3'd2:    frac = 10'd205;
         3'd3:    frac = 10'd307;
         3'd4:    frac = 10'd410;
         default: frac = 10'd0;
      endcase
      c.thr    = THR_WIDTH'({q, {THR_FRAC_SH{1'b0}}}) + THR_WIDTH'(frac);
      c.drive  = DRIVE_WIDTH'(DRIVE_Q_BASE)
               + DRIVE_WIDTH'(32'(amount) * 32'(DRIVE_Q_STEP));
      c.wet    = (amount > AMT_WIDTH'(AMT_ONE)) ? WET_WIDTH'(AMT_ONE) : WET_WIDTH'(amount);
      c.bypass = (amount <= AMT_WIDTH'(BYPASS_MAX));
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/bsw_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none

module bsw_div #(
   parameter int NW = 8,
   parameter int DW = 8,
   parameter int QW = 4,
   parameter int TW = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_vld,
   input  wire logic [NW-1:0] in_num,
   input  wire logic [DW-1:0] in_den,
   input  wire logic [TW-1:0] in_tag,
   output logic               out_vld,
   output logic [QW-1:0]      out_quo,
   output logic [TW-1:0]      out_tag
);

   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] nq_ff  [QW];
   logic [DW-1:0] den_ff [QW];
   logic [TW-1:0] tag_ff [QW];
   logic [QW-1:0] vld_ff;

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic [DW-1:0] rem_src;
      logic [QW-1:0] nq_src;
      logic [DW-1:0] den_src;
      logic [TW-1:0] tag_src;
      logic          vld_src;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] nq_in;

      // first stage takes the top of the numerator as its partial remainder
      if (i == 0) begin : g_first
         assign rem_src = DW'(in_num >> QW);
         assign nq_src  = in_num[QW-1:0];
         assign den_src = in_den;
         assign tag_src = in_tag;
         assign vld_src = in_vld;
      end else begin : g_next
         assign rem_src = rem_ff[i-1];
         assign nq_src  = nq_ff[i-1];
         assign den_src = den_ff[i-1];
         assign tag_src = tag_ff[i-1];
         assign vld_src = vld_ff[i-1];
      end

      // shift in the next numerator bit, subtract if it fits
      always_comb begin
         trial  = {rem_src, nq_src[QW-1]};
         diff   = trial - {1'b0, den_src};
         ge     = (trial >= {1'b0, den_src});
         rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
         nq_in  = {nq_src[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_src;
         end
         rem_ff[i] <= rem_in;
         nq_ff[i]  <= nq_in;
         den_ff[i] <= den_src;
         tag_ff[i] <= tag_src;
      end
   end

   assign out_vld = vld_ff[QW-1];
   assign out_quo = nq_ff[QW-1];
   assign out_tag = tag_ff[QW-1];

endmodule

`default_nettype wire

// ===== hdl/bsw_lane.sv =====
// one channel of the shaper: drive, three shapers, mix, dry/wet blend
`timescale 1ns / 1ps
`default_nettype none

module bsw_lane (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire bsw_pkg::cfg_type                       cfg,
   input  wire logic                                   in_vld,
   input  wire logic signed [bsw_pkg::SAMPLE_WIDTH-1:0] in_smp,
   output logic                                        out_vld,
   output logic signed [bsw_pkg::SAMPLE_WIDTH-1:0]     out_smp
);
   import bsw_pkg::*;

   localparam int SW   = SAMPLE_WIDTH;
   localparam int PW   = SW + DRIVE_WIDTH;
   localparam int RW   = M_WIDTH + DN_SHIFT + 1;
   localparam int HALF_UP = (1 << UP_SHIFT) >> 1;
   localparam int MXW  = SW + 2;
   localparam int AW   = SW + 18;
   localparam logic signed [AW-1:0] OUT_MAX = AW'((64'sd1 <<< (SW - 1)) - 64'sd1);
   localparam logic signed [AW-1:0] OUT_MIN = AW'(-(64'sd1 <<< (SW - 1)));

   // stage 1: magnitude times drive
   logic [SW-1:0]         mag;
   logic [PW-1:0]         dprod;
   logic [MNUM_WIDTH-1:0] mnum_in, mnum_ff;
   logic signed [SW-1:0]  s1_smp_ff;
   logic                  s1_vld_ff;

   always_comb begin
      mag     = in_smp[SW-1] ? SW'(-in_smp) : SW'(in_smp);
      dprod   = PW'(mag) * PW'(cfg.drive);
      mnum_in = (MNUM_WIDTH'(dprod) << UP_SHIFT) + MNUM_WIDTH'(M_HALF);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= in_vld;
      end
      mnum_ff   <= mnum_in;
      s1_smp_ff <= in_smp;
   end

   // scale to Q.24 magnitude: drop the power of two, divide by five by reciprocal
   logic [T_WIDTH-1:0]   mt;
   logic [2*T_WIDTH-1:0] mprod;
   logic [M_WIDTH-1:0]   m_in, m_ff;
   logic [SW-1:0]        sm_smp_ff;
   logic                 sm_vld_ff;

   always_comb begin
      mt    = T_WIDTH'(mnum_ff >> M_SHIFT);
      mprod = (2*T_WIDTH)'(mt) * (2*T_WIDTH)'(MSC_RECIP);
      m_in  = M_WIDTH'(mprod >> MSC_RECIP_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sm_vld_ff <= 1'b0;
      end else begin
         sm_vld_ff <= s1_vld_ff;
      end
      m_ff      <= m_in;
      sm_smp_ff <= s1_smp_ff;
   end

   // stage 2: square
   logic [2*M_WIDTH-1:0] msq;
   logic [X2_WIDTH-1:0]  x2_in, x2_ff;
   logic [M_WIDTH-1:0]   m2_ff;
   logic [SW-1:0]        s2_smp_ff;
   logic                 s2_vld_ff;

   always_comb begin
      msq   = m_ff * m_ff;
      x2_in = X2_WIDTH'((msq + (2*M_WIDTH)'(ONE_HALF)) >> INT_FRAC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= sm_vld_ff;
      end
      x2_ff     <= x2_in;
      m2_ff     <= m_ff;
      s2_smp_ff <= sm_smp_ff;
   end

   // stage 3: pade and soft clip numerators and divisors
   logic [X2_WIDTH:0]           pterm;
   logic [M_WIDTH+X2_WIDTH:0]   pmul;
   logic [PDEN_WIDTH-1:0]       pd_in, pd_ff;
   logic [PNUM_WIDTH-1:0]       pn_in, pn_ff;
   logic                        big_in, big_ff;
   logic [2*SMALL_WIDTH-1:0]    smul;
   logic [SDEN_WIDTH-1:0]       sd_in, sd_ff;
   logic [SNUM_WIDTH-1:0]       sn_in, sn_ff;
   logic [M_WIDTH-1:0]          m3_ff;
   logic [SW-1:0]               s3_smp_ff;
   logic                        s3_vld_ff;

   always_comb begin
      pterm  = (X2_WIDTH+1)'(PADE_C * ONE_Q) + (X2_WIDTH+1)'(x2_ff);
      pmul   = m2_ff * pterm;
      pd_in  = PDEN_WIDTH'(PADE_C * ONE_Q) + (PDEN_WIDTH'(x2_ff) << 3) + PDEN_WIDTH'(x2_ff);
      pn_in  = PNUM_WIDTH'(pmul) + PNUM_WIDTH'(pd_in >> 1);
      big_in = (m2_ff > M_WIDTH'(ONE_Q));
      smul   = m2_ff[SMALL_WIDTH-1:0] * x2_ff[SMALL_WIDTH-1:0];
      // reciprocal tail beyond one, cubic inside
      if (big_in) begin
         sd_in = (SDEN_WIDTH'(x2_ff) << 1) + SDEN_WIDTH'(x2_ff);
         sn_in = (SNUM_WIDTH'(1) << (2 * INT_FRAC)) + SNUM_WIDTH'(sd_in >> 1);
      end else begin
         sd_in = SDEN_WIDTH'(3 * ONE_Q);
         sn_in = SNUM_WIDTH'(smul) + SNUM_WIDTH'(sd_in >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
      pn_ff     <= pn_in;
      pd_ff     <= pd_in;
      sn_ff     <= sn_in;
      sd_ff     <= sd_in;
      big_ff    <= big_in;
      m3_ff     <= m2_ff;
      s3_smp_ff <= s2_smp_ff;
   end

   // pade and soft clip divisions run side by side
   logic                  p_vld;
   logic [Q_WIDTH-1:0]    p_quo;
   logic [SW+M_WIDTH-1:0] p_tag;
   logic                  sc_vld;
   logic [Q_WIDTH-1:0]    sc_quo;
   logic                  sc_big;

   bsw_div #(
      .NW(PNUM_WIDTH), .DW(PDEN_WIDTH), .QW(Q_WIDTH), .TW(SW + M_WIDTH)
   ) u_div_pade (
      .clock  (clock),
      .reset  (reset),
      .in_vld (s3_vld_ff),
      .in_num (pn_ff),
      .in_den (pd_ff),
      .in_tag ({s3_smp_ff, m3_ff}),
      .out_vld(p_vld),
      .out_quo(p_quo),
      .out_tag(p_tag)
   );

   bsw_div #(
      .NW(SNUM_WIDTH), .DW(SDEN_WIDTH), .QW(Q_WIDTH), .TW(1)
   ) u_div_soft (
      .clock  (clock),
      .reset  (reset),
      .in_vld (s3_vld_ff),
      .in_num (sn_ff),
      .in_den (sd_ff),
      .in_tag (big_ff),
      .out_vld(sc_vld),
      .out_quo(sc_quo),
      .out_tag(sc_big)
   );

   // stage 4: soft, hard and weighted sum
   logic [M_WIDTH-1:0]   m4;
   logic [M_WIDTH-1:0]   soft_mag;
   logic [M_WIDTH-1:0]   hard;
   logic [SUM_WIDTH-1:0] sum_in, sum_ff;
   logic [SW-1:0]        s4_smp_ff;
   logic                 s4_vld_ff;

   always_comb begin
      m4       = p_tag[M_WIDTH-1:0];
      soft_mag = sc_big ? M_WIDTH'(ONE_Q) - sc_quo : m4 - sc_quo;
      hard     = (m4 < M_WIDTH'(cfg.thr)) ? m4 : M_WIDTH'(cfg.thr);
      sum_in   = SUM_WIDTH'(5) * SUM_WIDTH'(p_quo) + SUM_WIDTH'(3) * SUM_WIDTH'(soft_mag)
               + SUM_WIDTH'(2) * SUM_WIDTH'(hard) + SUM_WIDTH'(MIX_HALF);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= p_vld & sc_vld;
      end
      sum_ff    <= sum_in;
      s4_smp_ff <= p_tag[SW+M_WIDTH-1:M_WIDTH];
   end

   // stage 5: divide the sum by ten through its reciprocal
   logic [2*SUM_WIDTH-1:0] rprod;
   logic [M_WIDTH-1:0]     mix_in, mix_ff;
   logic [SW-1:0]          s5_smp_ff;
   logic                   s5_vld_ff;

   always_comb begin
      rprod  = (2*SUM_WIDTH)'(sum_ff) * (2*SUM_WIDTH)'(RECIP10);
      mix_in = M_WIDTH'(rprod >> RECIP10_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else begin
         s5_vld_ff <= s4_vld_ff;
      end
      mix_ff    <= mix_in;
      s5_smp_ff <= s4_smp_ff;
   end

   // stage 6: back to sample format, signed, and weight dry and wet
   logic [RW-1:0]            rw;
   logic [SW:0]              mmag;
   logic signed [MXW-1:0]    mixs;
   logic [WET_WIDTH-1:0]     dry;
   logic signed [SW+15:0]    p1_in, p1_ff;
   logic signed [SW+17:0]    p2_in, p2_ff;
   logic signed [SW-1:0]     s5_smp;
   logic [SW-1:0]            s6_smp_ff;
   logic                     s6_vld_ff;

   always_comb begin
      s5_smp = $signed(s5_smp_ff);
      rw     = ((RW'(mix_ff) + RW'(HALF_UP)) >> UP_SHIFT) << DN_SHIFT;
      mmag   = (SW+1)'(rw);
      mixs   = s5_smp[SW-1] ? -$signed({1'b0, mmag}) : $signed({1'b0, mmag});
      dry    = WET_WIDTH'(AMT_ONE) - cfg.wet;
      p1_in  = s5_smp * $signed({1'b0, dry});
      p2_in  = mixs * $signed({1'b0, cfg.wet});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else begin
         s6_vld_ff <= s5_vld_ff;
      end
      p1_ff     <= p1_in;
      p2_ff     <= p2_in;
      s6_smp_ff <= s5_smp_ff;
   end

   // stage 7: blend, round, saturate, or pass the sample on bypass
   logic signed [AW-1:0] acc;
   logic [AW-1:0]        aab;
   logic [AW-1:0]        qa;
   logic signed [AW-1:0] r;
   logic signed [SW-1:0] out_in, out_ff;
   logic                 out_vld_ff;

   always_comb begin
      acc = AW'(p1_ff) + AW'(p2_ff);
      aab = acc[AW-1] ? AW'(-acc) : AW'(acc);
      qa  = (aab + AW'(AMT_ONE >> 1)) >> AMT_BITS;
      r   = acc[AW-1] ? -$signed(qa) : $signed(qa);
      if (cfg.bypass) begin
         out_in = $signed(s6_smp_ff);
      end else if (r > OUT_MAX) begin
         out_in = SW'(OUT_MAX);
      end else if (r < OUT_MIN) begin
         out_in = SW'(OUT_MIN);
      end else begin
         out_in = SW'(r);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= s6_vld_ff;
      end
      out_ff <= out_in;
   end

   assign out_vld = out_vld_ff;
   assign out_smp = out_ff;

endmodule

`default_nettype wire

// ===== hdl/blended_saturation_waveshaper.sv =====
// top level: amount register, input register, two channel lanes, output merge
//
// Stereo waveshaper that accepts one sample pair on every clock: busy never
// rises and start may be held high indefinitely. Each pair comes out on
// rsp_data with a one-cycle rsp_valid strobe; the receiver cannot hold
// results back, so it must take every strobe.
// The path runs through two 28-stage restoring divider pipelines per channel
// (the Pade and soft-clip divisions run in parallel) plus ten further
// register stages: input register, drive product, reciprocal scaling, square,
// divider setup, mix sum, divide by ten, dry/wet weighting, blend and output
// merge.
// Write the amount register through csr_we and csr_wdata only while no pair
// is in flight; the new setting applies to the next pair accepted.
`timescale 1ns / 1ps
`default_nettype none

module blended_saturation_waveshaper (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire bsw_pkg::req_type               req_data,
   output logic                                rsp_valid,
   output bsw_pkg::rsp_type                    rsp_data,
   input  wire logic                           csr_we,
   input  wire logic [bsw_pkg::AMT_WIDTH-1:0]  csr_wdata
);
   import bsw_pkg::*;

   // amount register, kept in decoded form
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= cfg_decode('0);
      end else if (csr_we) begin
         cfg_ff <= cfg_decode(csr_wdata);
      end
   end

   // pipeline never stalls
   assign busy = 1'b0;

   // input register
   req_type in_ff;
   logic    in_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start & ~busy;
      end
      if (start & ~busy) begin
         in_ff <= req_data;
      end
   end

   // one lane per channel
   logic                           l_vld, r_vld;
   logic signed [SAMPLE_WIDTH-1:0] l_smp, r_smp;

   bsw_lane u_lane_left (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .in_vld (in_vld_ff),
      .in_smp (in_ff.left_sample),
      .out_vld(l_vld),
      .out_smp(l_smp)
   );

   bsw_lane u_lane_right (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .in_vld (in_vld_ff),
      .in_smp (in_ff.right_sample),
      .out_vld(r_vld),
      .out_smp(r_smp)
   );

   // merge both lanes into the result item
   rsp_type rsp_in, rsp_ff;
   logic    rsp_valid_ff;

   always_comb begin
      rsp_in.left_out  = l_smp;
      rsp_in.right_out = r_smp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= l_vld & r_vld;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // every result traces back to an earlier start
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(start, TOP_LATENCY))
      else $error("result without matching start");

   // both lanes run in lock step
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      l_vld == r_vld)
      else $error("lane valids disagree");

   // bypass decode follows the written amount
   a_bypass_decode: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> cfg_ff.bypass == ($past(csr_wdata) <= AMT_WIDTH'(BYPASS_MAX)))
      else $error("bypass decode mismatch");

   // zero wet only happens with bypass on
   a_wet_bypass: assert property (@(posedge clock) disable iff (reset)
      cfg_ff.wet == '0 |-> cfg_ff.bypass)
      else $error("zero wet without bypass");

endmodule

`default_nettype wire
